### rtl/core/rrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_pkg: shared types for the rectangle region set
// Opcodes, status codes, word formats and the controller/datapath link.
// ----------------------------------------------------------------------------
package rrs_pkg;

    localparam int MAX_RECTS_DEF      = 16;
    localparam int SCRATCH_PIECES_DEF = 64;
    localparam int COORD_BITS_DEF     = 16;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_REMOVE,
        OP_INTERSECT,
        OP_POINT,
        OP_CONTAIN,
        OP_BBOX,
        OP_CLEAR,
        OP_READ
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK,
        ST_OVERFLOW,
        ST_BAD_INDEX
    } t_status;

    typedef struct packed {
        t_opcode            opcode;
        logic signed [15:0] left_x;
        logic signed [15:0] top_y;
        logic [14:0]        width;
        logic [14:0]        height;
        logic [3:0]         entry_index;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic               hit;
        logic [4:0]         entry_count;
        logic signed [15:0] out_left_x;
        logic signed [15:0] out_top_y;
        logic [15:0]        out_width;
        logic [15:0]        out_height;
    } t_out_word;

    // datapath micro-operations, one per cycle
    typedef enum logic [4:0] {
        U_NOP,
        U_LO_INIT,
        U_RD_TI,
        U_CUT_LD,
        U_SUB_RD,
        U_SUB_LD,
        U_CLIP,
        U_SUB_EMIT,
        U_FLIP,
        U_REM_INIT,
        U_CHK,
        U_CP_INIT,
        U_CP_RD,
        U_CP_WR,
        U_COMMIT,
        U_IX_INIT,
        U_IX_LD,
        U_IX_WR,
        U_IX_END,
        U_PT_TEST,
        U_BB_ACC,
        U_RE_RD,
        U_CLEAR,
        U_RES
    } t_uop;

    typedef struct packed {
        t_uop uop;
        logic accept;
    } t_cmd;

    typedef struct packed {
        t_opcode op;
        logic    i_end;
        logic    k_zero;
        logic    j_end;
        logic    cp_end;
        logic    last_part;
        logic    emit_ovf;
        logic    fits;
        logic    idx_ok;
        logic    out_free;
    } t_stat;

endpackage

### rtl/core/rrs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_ctrl: operation sequencer
// Walks each opcode through its micro-operation sequence.
// ----------------------------------------------------------------------------
module rrs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rrs_pkg::t_stat i_stat,
    output logic           o_ready,
    output rrs_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_LO_INIT,
        S_LO_TEST,
        S_CUT_RD,
        S_CUT_LD,
        S_SUB_RD,
        S_SUB_LD,
        S_SUB_CLIP,
        S_SUB_EMIT,
        S_SUB_END,
        S_LO_DONE,
        S_REM_INIT,
        S_REM_CHK,
        S_CP_INIT,
        S_CP_RD,
        S_CP_WR,
        S_COMMIT,
        S_IX_INIT,
        S_IX_RD,
        S_IX_LD,
        S_IX_CLIP,
        S_IX_WR,
        S_IX_END,
        S_PT_RD,
        S_PT_TEST,
        S_BB_RD,
        S_BB_ACC,
        S_RE_RD,
        S_CLR,
        S_RES
    } t_state;

    t_state        r_state, n_state;
    logic          r_rdy, n_rdy;
    rrs_pkg::t_uop uop;

    always_comb begin
        n_state = r_state;
        uop     = rrs_pkg::U_NOP;
        case (r_state)
            S_IDLE: begin
                if (r_rdy && i_valid) n_state = S_DISP;
            end
            S_DISP: begin
                case (i_stat.op)
                    rrs_pkg::OP_ADD, rrs_pkg::OP_CONTAIN: n_state = S_LO_INIT;
                    rrs_pkg::OP_REMOVE:    n_state = S_REM_INIT;
                    rrs_pkg::OP_INTERSECT: n_state = S_IX_INIT;
                    rrs_pkg::OP_POINT:     n_state = S_PT_RD;
                    rrs_pkg::OP_BBOX:      n_state = S_BB_RD;
                    rrs_pkg::OP_CLEAR:     n_state = S_CLR;
                    default:               n_state = i_stat.idx_ok ? S_RE_RD : S_RES;
                endcase
            end
            S_LO_INIT: begin
                uop     = rrs_pkg::U_LO_INIT;
                n_state = S_LO_TEST;
            end
            S_LO_TEST: begin
                n_state = (i_stat.i_end || i_stat.k_zero) ? S_LO_DONE : S_CUT_RD;
            end
            S_CUT_RD: begin
                uop     = rrs_pkg::U_RD_TI;
                n_state = S_CUT_LD;
            end
            S_CUT_LD: begin
                uop     = rrs_pkg::U_CUT_LD;
                n_state = S_SUB_RD;
            end
            S_SUB_RD: begin
                uop     = rrs_pkg::U_SUB_RD;
                n_state = i_stat.j_end ? S_SUB_END : S_SUB_LD;
            end
            S_SUB_LD: begin
                uop     = rrs_pkg::U_SUB_LD;
                n_state = S_SUB_CLIP;
            end
            S_SUB_CLIP: begin
                uop     = rrs_pkg::U_CLIP;
                n_state = S_SUB_EMIT;
            end
            S_SUB_EMIT: begin
                uop = rrs_pkg::U_SUB_EMIT;
                if (i_stat.emit_ovf) n_state = S_RES;
                else if (i_stat.last_part) n_state = S_SUB_RD;
            end
            S_SUB_END: begin
                uop     = rrs_pkg::U_FLIP;
                n_state = (i_stat.op == rrs_pkg::OP_REMOVE) ? S_REM_CHK : S_LO_TEST;
            end
            S_LO_DONE: begin
                uop = rrs_pkg::U_CHK;
                if (i_stat.op == rrs_pkg::OP_CONTAIN) n_state = S_RES;
                else n_state = i_stat.fits ? S_CP_INIT : S_RES;
            end
            S_REM_INIT: begin
                uop     = rrs_pkg::U_REM_INIT;
                n_state = S_SUB_RD;
            end
            S_REM_CHK: begin
                uop     = rrs_pkg::U_CHK;
                n_state = i_stat.fits ? S_CP_INIT : S_RES;
            end
            S_CP_INIT: begin
                uop     = rrs_pkg::U_CP_INIT;
                n_state = S_CP_RD;
            end
            S_CP_RD: begin
                uop     = rrs_pkg::U_CP_RD;
                n_state = i_stat.cp_end ? S_COMMIT : S_CP_WR;
            end
            S_CP_WR: begin
                uop     = rrs_pkg::U_CP_WR;
                n_state = S_CP_RD;
            end
            S_COMMIT: begin
                uop     = rrs_pkg::U_COMMIT;
                n_state = S_RES;
            end
            S_IX_INIT: begin
                uop     = rrs_pkg::U_IX_INIT;
                n_state = S_IX_RD;
            end
            S_IX_RD: begin
                uop     = rrs_pkg::U_RD_TI;
                n_state = i_stat.i_end ? S_IX_END : S_IX_LD;
            end
            S_IX_LD: begin
                uop     = rrs_pkg::U_IX_LD;
                n_state = S_IX_CLIP;
            end
            S_IX_CLIP: begin
                uop     = rrs_pkg::U_CLIP;
                n_state = S_IX_WR;
            end
            S_IX_WR: begin
                uop     = rrs_pkg::U_IX_WR;
                n_state = S_IX_RD;
            end
            S_IX_END: begin
                uop     = rrs_pkg::U_IX_END;
                n_state = S_RES;
            end
            S_PT_RD: begin
                uop     = rrs_pkg::U_RD_TI;
                n_state = i_stat.i_end ? S_RES : S_PT_TEST;
            end
            S_PT_TEST: begin
                uop     = rrs_pkg::U_PT_TEST;
                n_state = S_PT_RD;
            end
            S_BB_RD: begin
                uop     = rrs_pkg::U_RD_TI;
                n_state = i_stat.i_end ? S_RES : S_BB_ACC;
            end
            S_BB_ACC: begin
                uop     = rrs_pkg::U_BB_ACC;
                n_state = S_BB_RD;
            end
            S_RE_RD: begin
                uop     = rrs_pkg::U_RE_RD;
                n_state = S_RES;
            end
            S_CLR: begin
                uop     = rrs_pkg::U_CLEAR;
                n_state = S_RES;
            end
            S_RES: begin
                uop = rrs_pkg::U_RES;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        n_rdy = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rdy   <= 1'b1;
        end else begin
            r_state <= n_state;
            r_rdy   <= n_rdy;
        end
    end

    assign o_ready    = r_rdy;
    assign o_cmd.uop  = uop;
    assign o_cmd.accept = r_rdy && i_valid;

endmodule

### rtl/core/rrs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_datapath: rectangle table, scratch banks and box arithmetic
// Executes one micro-operation per cycle; holds the result word register.
// ----------------------------------------------------------------------------
module rrs_datapath #(
    parameter int MAX_RECTS      = rrs_pkg::MAX_RECTS_DEF,
    parameter int SCRATCH_PIECES = rrs_pkg::SCRATCH_PIECES_DEF,
    parameter int COORD_BITS     = rrs_pkg::COORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrs_pkg::t_in_word  i_word,
    input  rrs_pkg::t_cmd      i_cmd,
    input  logic               i_ready,
    output rrs_pkg::t_stat     o_stat,
    output logic               o_valid,
    output rrs_pkg::t_out_word o_word
);

    localparam int BW  = (COORD_BITS > 16) ? COORD_BITS : 16;
    localparam int CW  = BW + 2;
    localparam int TAW = $clog2(MAX_RECTS);
    localparam int CNW = $clog2(MAX_RECTS + 1);
    localparam int SCW = $clog2(SCRATCH_PIECES + 1);
    localparam int SAW = $clog2(2 * SCRATCH_PIECES);
    localparam int JMX = (MAX_RECTS > SCRATCH_PIECES) ? MAX_RECTS : SCRATCH_PIECES;
    localparam int JW  = $clog2(JMX + 1);
    localparam logic [63:0] SIZE_CAP = (64'd1 << COORD_BITS) - 64'd1;

    typedef struct packed {
        logic signed [CW-1:0] l;
        logic signed [CW-1:0] t;
        logic signed [CW-1:0] r;
        logic signed [CW-1:0] b;
    } t_box;

    function automatic logic signed [CW-1:0] sx(input logic [15:0] f);
        logic [31:0] z;
        z = 32'(f);
        return CW'($signed(z[COORD_BITS-1:0]));
    endfunction

    function automatic logic [15:0] sat16(input logic signed [CW-1:0] d);
        logic [63:0] du;
        du = 64'(d);
        if (d <= 0) du = '0;
        else if (du > SIZE_CAP) du = SIZE_CAP;
        return du[15:0];
    endfunction

    function automatic logic [SAW-1:0] scr_addr(input logic bank, input logic [31:0] idx);
        return bank ? SAW'(32'(SCRATCH_PIECES) + idx) : SAW'(idx);
    endfunction

    // storage
    t_box tbl_mem [MAX_RECTS];
    t_box scr_mem [2*SCRATCH_PIECES];
    t_box r_tbl_q, r_scr_q;

    rrs_pkg::t_opcode   r_op;
    t_box               r_in, r_cut, r_src, r_q, r_bb;
    logic [3:0]         r_idx;
    logic [CNW-1:0]     r_count, r_i, r_n;
    logic [JW-1:0]      r_j;
    logic [SCW-1:0]     r_k, r_nk;
    logic               r_cur, r_fail, r_hit, r_valid;
    logic [1:0]         r_part;
    rrs_pkg::t_out_word r_out, res;

    t_box           clip_q, piece, in_box;
    logic           q_ne, in_ne, emit, last, full, fits, out_free, pt_in;
    logic           tbl_we, scr_we;
    logic [TAW-1:0] tbl_wa, tbl_ra;
    logic [SAW-1:0] scr_wa, scr_ra;
    t_box           tbl_wd, scr_wd;
    rrs_pkg::t_uop  uop;

    assign uop = i_cmd.uop;

    always_comb begin
        in_box.l = sx(i_word.left_x);
        in_box.t = sx(i_word.top_y);
        in_box.r = in_box.l + $signed(CW'(i_word.width));
        in_box.b = in_box.t + $signed(CW'(i_word.height));

        clip_q = r_src;
        if (r_cut.l > clip_q.l) clip_q.l = r_cut.l;
        if (r_cut.t > clip_q.t) clip_q.t = r_cut.t;
        if (r_cut.r < clip_q.r) clip_q.r = r_cut.r;
        if (r_cut.b < clip_q.b) clip_q.b = r_cut.b;

        q_ne  = (r_q.r > r_q.l) && (r_q.b > r_q.t);
        in_ne = (r_in.r > r_in.l) && (r_in.b > r_in.t);

        // pieces around the overlap: above, left, right, below
        piece = r_src;
        emit  = 1'b0;
        last  = 1'b1;
        if (!q_ne) begin
            emit = (r_part == 2'd0);
        end else begin
            last = (r_part == 2'd3);
            case (r_part)
                2'd0: begin
                    emit    = r_q.t > r_src.t;
                    piece.b = r_q.t;
                end
                2'd1: begin
                    emit    = r_q.l > r_src.l;
                    piece.t = r_q.t;
                    piece.r = r_q.l;
                    piece.b = r_q.b;
                end
                2'd2: begin
                    emit    = r_q.r < r_src.r;
                    piece.l = r_q.r;
                    piece.t = r_q.t;
                    piece.b = r_q.b;
                end
                default: begin
                    emit    = r_q.b < r_src.b;
                    piece.t = r_q.b;
                end
            endcase
        end
        full = 32'(r_nk) >= SCRATCH_PIECES;
        fits = ((r_op == rrs_pkg::OP_ADD) ? 32'(r_count) + 32'(r_k) : 32'(r_k))
               <= MAX_RECTS;
        out_free = !r_valid || i_ready;
        pt_in = (r_in.l >= r_tbl_q.l) && (r_in.l < r_tbl_q.r) &&
                (r_in.t >= r_tbl_q.t) && (r_in.t < r_tbl_q.b);

        tbl_we = (uop == rrs_pkg::U_CP_WR) || ((uop == rrs_pkg::U_IX_WR) && q_ne);
        tbl_wa = (uop == rrs_pkg::U_CP_WR) ? TAW'(32'(r_n) + 32'(r_j)) : TAW'(r_n);
        tbl_wd = (uop == rrs_pkg::U_CP_WR) ? r_scr_q : r_q;
        // entry read stays addressed while the result word waits
        case (uop)
            rrs_pkg::U_SUB_RD:                 tbl_ra = TAW'(r_j);
            rrs_pkg::U_RE_RD, rrs_pkg::U_RES:  tbl_ra = TAW'(r_idx);
            default:                           tbl_ra = TAW'(r_i);
        endcase

        scr_we = ((uop == rrs_pkg::U_LO_INIT) && in_ne) ||
                 ((uop == rrs_pkg::U_SUB_EMIT) && emit && !full);
        scr_wa = (uop == rrs_pkg::U_LO_INIT) ? scr_addr(1'b0, 32'd0)
                                             : scr_addr(!r_cur, 32'(r_nk));
        scr_wd = (uop == rrs_pkg::U_LO_INIT) ? r_in : piece;
        scr_ra = scr_addr(r_cur, 32'(r_j));
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
        r_tbl_q <= tbl_mem[tbl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (scr_we) scr_mem[scr_wa] <= scr_wd;
        r_scr_q <= scr_mem[scr_ra];
    end

    // result word
    always_comb begin
        res             = '0;
        res.status      = rrs_pkg::ST_OK;
        res.entry_count = 5'(32'(r_count));
        case (r_op)
            rrs_pkg::OP_ADD, rrs_pkg::OP_REMOVE: begin
                if (r_fail) res.status = rrs_pkg::ST_OVERFLOW;
            end
            rrs_pkg::OP_POINT: res.hit = r_hit;
            rrs_pkg::OP_CONTAIN: begin
                if (r_fail) res.status = rrs_pkg::ST_OVERFLOW;
                res.hit = !r_fail && (r_k == '0);
            end
            rrs_pkg::OP_BBOX: begin
                if (r_count != '0) begin
                    res.out_left_x = r_bb.l[15:0];
                    res.out_top_y  = r_bb.t[15:0];
                    res.out_width  = sat16(r_bb.r - r_bb.l);
                    res.out_height = sat16(r_bb.b - r_bb.t);
                end
            end
            rrs_pkg::OP_READ: begin
                if (32'(r_idx) < 32'(r_count)) begin
                    res.out_left_x = r_tbl_q.l[15:0];
                    res.out_top_y  = r_tbl_q.t[15:0];
                    res.out_width  = sat16(r_tbl_q.r - r_tbl_q.l);
                    res.out_height = sat16(r_tbl_q.b - r_tbl_q.t);
                end else begin
                    res.status = rrs_pkg::ST_BAD_INDEX;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (uop == rrs_pkg::U_RES && out_free) begin
                r_valid <= 1'b1;
                r_out   <= res;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end

            if (i_cmd.accept) begin
                r_op   <= i_word.opcode;
                r_in   <= in_box;
                r_idx  <= i_word.entry_index;
                r_i    <= '0;
                r_j    <= '0;
                r_nk   <= '0;
                r_n    <= '0;
                r_cur  <= 1'b0;
                r_fail <= 1'b0;
                r_hit  <= 1'b0;
            end

            case (uop)
                rrs_pkg::U_LO_INIT: begin
                    r_k   <= in_ne ? SCW'(1) : '0;
                    r_cur <= 1'b0;
                    r_i   <= '0;
                end
                rrs_pkg::U_CUT_LD: begin
                    r_cut <= r_tbl_q;
                    r_j   <= '0;
                    r_nk  <= '0;
                end
                rrs_pkg::U_SUB_LD: begin
                    r_src  <= (r_op == rrs_pkg::OP_REMOVE) ? r_tbl_q : r_scr_q;
                    r_part <= 2'd0;
                end
                rrs_pkg::U_CLIP: r_q <= clip_q;
                rrs_pkg::U_SUB_EMIT: begin
                    if (emit && !full) r_nk <= r_nk + 1'b1;
                    if (emit && full) r_fail <= 1'b1;
                    r_part <= r_part + 2'd1;
                    if (last) r_j <= r_j + 1'b1;
                end
                rrs_pkg::U_FLIP: begin
                    r_cur <= !r_cur;
                    r_k   <= r_nk;
                    r_i   <= r_i + 1'b1;
                end
                rrs_pkg::U_REM_INIT: begin
                    r_cut <= r_in;
                    r_cur <= 1'b1;     // pieces land in bank 0
                    r_j   <= '0;
                    r_nk  <= '0;
                end
                rrs_pkg::U_CHK: begin
                    if (r_op != rrs_pkg::OP_CONTAIN && !fits) r_fail <= 1'b1;
                end
                rrs_pkg::U_CP_INIT: begin
                    r_j <= '0;
                    r_n <= (r_op == rrs_pkg::OP_ADD) ? r_count : '0;
                end
                rrs_pkg::U_CP_WR: r_j <= r_j + 1'b1;
                rrs_pkg::U_COMMIT: begin
                    r_count <= (r_op == rrs_pkg::OP_ADD) ? CNW'(32'(r_count) + 32'(r_k))
                                                         : CNW'(r_k);
                end
                rrs_pkg::U_IX_INIT: begin
                    r_cut <= r_in;
                    r_i   <= '0;
                    r_n   <= '0;
                end
                rrs_pkg::U_IX_LD: r_src <= r_tbl_q;
                rrs_pkg::U_IX_WR: begin
                    if (q_ne) r_n <= r_n + 1'b1;
                    r_i <= r_i + 1'b1;
                end
                rrs_pkg::U_IX_END: r_count <= r_n;
                rrs_pkg::U_PT_TEST: begin
                    if (pt_in) r_hit <= 1'b1;
                    r_i <= r_i + 1'b1;
                end
                rrs_pkg::U_BB_ACC: begin
                    if (r_i == '0) begin
                        r_bb <= r_tbl_q;
                    end else begin
                        if (r_tbl_q.l < r_bb.l) r_bb.l <= r_tbl_q.l;
                        if (r_tbl_q.t < r_bb.t) r_bb.t <= r_tbl_q.t;
                        if (r_tbl_q.r > r_bb.r) r_bb.r <= r_tbl_q.r;
                        if (r_tbl_q.b > r_bb.b) r_bb.b <= r_tbl_q.b;
                    end
                    r_i <= r_i + 1'b1;
                end
                rrs_pkg::U_CLEAR: r_count <= '0;
                default: ;
            endcase
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.i_end     = 32'(r_i) >= 32'(r_count);
    assign o_stat.k_zero    = (r_k == '0);
    assign o_stat.j_end     = 32'(r_j) >= ((r_op == rrs_pkg::OP_REMOVE) ? 32'(r_count)
                                                                         : 32'(r_k));
    assign o_stat.cp_end    = 32'(r_j) >= 32'(r_k);
    assign o_stat.last_part = last;
    assign o_stat.emit_ovf  = emit && full;
    assign o_stat.fits      = fits;
    assign o_stat.idx_ok    = 32'(r_idx) < 32'(r_count);
    assign o_stat.out_free  = out_free;

    assign o_valid = r_valid;
    assign o_word  = r_out;

endmodule

### rtl/core/rectangle_region_set_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_region_set_top: disjoint rectangle set with region operations
// Add, remove, intersect, point and containment tests, bounding box, clear
// and entry read over a table of disjoint rectangles.
// ----------------------------------------------------------------------------
//  channel  | signals                      | word
//  ---------+------------------------------+-------------------------------
//  input    | i_valid / o_ready / i_word   | opcode, rectangle, entry index
//  output   | o_valid / i_ready / o_word   | status, hit, count, box
//
//  One operation at a time; o_ready is high only while the sequencer idles.
//  Clear and read need no table walk; point test and bounding box read each
//  entry in turn, and intersect reads, clips and writes back each entry.
//  Add and containment cut the rectangle by each table entry visited, and
//  remove cuts every entry by it; each piece is read, then kept or split,
//  and for add and remove the pieces, if they all fit, go into the table.
//  Reset empties the set at once; no clearing pass. A finished word waits in
//  the output register while the next input word is taken.
// ----------------------------------------------------------------------------
module rectangle_region_set_top #(
    parameter int MAX_RECTS      = rrs_pkg::MAX_RECTS_DEF,
    parameter int SCRATCH_PIECES = rrs_pkg::SCRATCH_PIECES_DEF,
    parameter int COORD_BITS     = rrs_pkg::COORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rrs_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_ready,
    output rrs_pkg::t_out_word o_word
);

    rrs_pkg::t_cmd  cmd;
    rrs_pkg::t_stat stat;

    rrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    rrs_datapath #(
        .MAX_RECTS      (MAX_RECTS),
        .SCRATCH_PIECES (SCRATCH_PIECES),
        .COORD_BITS     (COORD_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (i_word),
        .i_cmd   (cmd),
        .i_ready (i_ready),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_word  (o_word)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while an operation is in progress");

    a_hit_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.status != rrs_pkg::ST_OK) |-> !o_word.hit)
        else $error("hit reported with an error status");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_word.entry_count) <= MAX_RECTS))
        else $error("entry count beyond table size");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: rectangle region set testbench
// Directed and random opcode words run through the block; every output word
// is checked against an in-bench model of the disjoint rectangle table.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NRECT = rrs_pkg::MAX_RECTS_DEF;
    localparam int NSCR  = rrs_pkg::SCRATCH_PIECES_DEF;
    localparam int WDOG  = 200000;

    typedef struct {
        longint l, t, r, b;
    } t_box;

    logic               clk, rst_n;
    logic               in_valid, out_ready;
    rrs_pkg::t_in_word  in_word;
    logic               in_ready, out_valid;
    rrs_pkg::t_out_word out_word;

    rectangle_region_set_top DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_word(in_word), .o_valid(out_valid), .i_ready(out_ready), .o_word(out_word)
    );

    // model state
    t_box   rtab[NRECT];
    int     rcnt;
    t_box   bank_a[NSCR];
    t_box   bank_b[NSCR];

    rrs_pkg::t_in_word  pend_words[$];
    rrs_pkg::t_out_word exp_words[$];
    int                 n_err, n_sent, n_got, idle_cyc;
    bit                 calm;
    int                 op_seen[8];

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic void add_pending(rrs_pkg::t_in_word w);
        pend_words.insert(pend_words.size(), w);
    endfunction

    function automatic void add_expected(rrs_pkg::t_out_word w);
        exp_words.insert(exp_words.size(), w);
    endfunction

    function automatic t_box clip_box(t_box a, t_box c);
        if (c.l > a.l) a.l = c.l;
        if (c.t > a.t) a.t = c.t;
        if (c.r < a.r) a.r = c.r;
        if (c.b < a.b) a.b = c.b;
        return a;
    endfunction

    function automatic bit has_area(t_box a);
        return a.r > a.l && a.b > a.t;
    endfunction

    function automatic bit put_piece(ref t_box d[NSCR], ref int k, input longint l,
                                     input longint t, input longint r, input longint b);
        if (k >= NSCR) return 0;
        d[k] = '{l, t, r, b};
        k++;
        return 1;
    endfunction

    // pieces of src[0..n) outside cut
    function automatic bit cut_out(t_box cut, ref t_box src[NSCR], input int n,
                                   ref t_box dst[NSCR], output int dn);
        int   k;
        t_box q, s;
        bit   ok;
        k = 0;
        dn = 0;
        for (int i = 0; i < n; i++) begin
            s = src[i];
            q = clip_box(s, cut);
            ok = 1;
            if (!has_area(q)) begin
                ok = put_piece(dst, k, s.l, s.t, s.r, s.b);
            end else begin
                if (ok && q.t > s.t) ok = put_piece(dst, k, s.l, s.t, s.r, q.t);
                if (ok && q.l > s.l) ok = put_piece(dst, k, s.l, q.t, q.l, q.b);
                if (ok && q.r < s.r) ok = put_piece(dst, k, q.r, q.t, s.r, q.b);
                if (ok && q.b < s.b) ok = put_piece(dst, k, s.l, q.b, s.r, s.b);
            end
            if (!ok) return 0;
        end
        dn = k;
        return 1;
    endfunction

    // uncovered part of r; result left in bank_a; -1 on overflow
    function automatic int uncovered(t_box r);
        int k, nk;
        bit ok;
        k = 0;
        if (has_area(r)) begin
            bank_a[0] = r;
            k = 1;
        end
        for (int i = 0; i < rcnt; i++) begin
            ok = cut_out(rtab[i], bank_a, k, bank_b, nk);
            if (!ok) return -1;
            bank_a = bank_b;
            k = nk;
        end
        return k;
    endfunction

    function automatic logic [15:0] clamp_size(longint d);
        if (d < 0) d = 0;
        if (d > 65535) d = 65535;
        return d[15:0];
    endfunction

    function automatic rrs_pkg::t_out_word region_step(rrs_pkg::t_in_word w);
        rrs_pkg::t_out_word o;
        t_box r, q, bb;
        int n;
        bit ok;
        o = '0;
        o.status = rrs_pkg::ST_OK;
        r.l = longint'(w.left_x);
        r.t = longint'(w.top_y);
        r.r = r.l + w.width;
        r.b = r.t + w.height;
        case (w.opcode)
            rrs_pkg::OP_ADD: begin
                n = uncovered(r);
                if (n < 0 || rcnt + n > NRECT) o.status = rrs_pkg::ST_OVERFLOW;
                else begin
                    for (int i = 0; i < n; i++) rtab[rcnt + i] = bank_a[i];
                    rcnt += n;
                end
            end
            rrs_pkg::OP_REMOVE: begin
                for (int i = 0; i < NRECT; i++) bank_b[i] = rtab[i];
                ok = cut_out(r, bank_b, rcnt, bank_a, n);
                if (!ok || n > NRECT) o.status = rrs_pkg::ST_OVERFLOW;
                else begin
                    for (int i = 0; i < n; i++) rtab[i] = bank_a[i];
                    rcnt = n;
                end
            end
            rrs_pkg::OP_INTERSECT: begin
                n = 0;
                for (int i = 0; i < rcnt; i++) begin
                    q = clip_box(rtab[i], r);
                    if (has_area(q)) begin
                        rtab[n] = q;
                        n++;
                    end
                end
                rcnt = n;
            end
            rrs_pkg::OP_POINT: begin
                for (int i = 0; i < rcnt; i++)
                    if (r.l >= rtab[i].l && r.l < rtab[i].r && r.t >= rtab[i].t &&
                        r.t < rtab[i].b) o.hit = 1;
            end
            rrs_pkg::OP_CONTAIN: begin
                n = uncovered(r);
                if (n < 0) o.status = rrs_pkg::ST_OVERFLOW;
                else o.hit = (n == 0);
            end
            rrs_pkg::OP_BBOX: begin
                if (rcnt > 0) begin
                    bb = rtab[0];
                    for (int i = 1; i < rcnt; i++) begin
                        if (rtab[i].l < bb.l) bb.l = rtab[i].l;
                        if (rtab[i].t < bb.t) bb.t = rtab[i].t;
                        if (rtab[i].r > bb.r) bb.r = rtab[i].r;
                        if (rtab[i].b > bb.b) bb.b = rtab[i].b;
                    end
                    o.out_left_x = bb.l[15:0];
                    o.out_top_y  = bb.t[15:0];
                    o.out_width  = clamp_size(bb.r - bb.l);
                    o.out_height = clamp_size(bb.b - bb.t);
                end
            end
            rrs_pkg::OP_CLEAR: rcnt = 0;
            default: begin
                if (w.entry_index >= rcnt) o.status = rrs_pkg::ST_BAD_INDEX;
                else begin
                    bb = rtab[w.entry_index];
                    o.out_left_x = bb.l[15:0];
                    o.out_top_y  = bb.t[15:0];
                    o.out_width  = clamp_size(bb.r - bb.l);
                    o.out_height = clamp_size(bb.b - bb.t);
                end
            end
        endcase
        o.entry_count = rcnt[4:0];
        return o;
    endfunction

    task automatic report_err(string what, rrs_pkg::t_out_word got,
                              rrs_pkg::t_out_word want);
        n_err++;
        $display("mismatch %s: got %p want %p", what, got, want);
    endtask

    function automatic rrs_pkg::t_in_word mk_word(rrs_pkg::t_opcode op, int x, int y,
                                                  int w, int h, int ix);
        rrs_pkg::t_in_word v;
        v.opcode = op;
        v.left_x = x[15:0];
        v.top_y = y[15:0];
        v.width = w[14:0];
        v.height = h[14:0];
        v.entry_index = ix[3:0];
        return v;
    endfunction

    // mostly small rectangles in a small field so they overlap
    function automatic rrs_pkg::t_in_word rand_word();
        rrs_pkg::t_in_word v;
        int sel;
        sel = $urandom_range(0, 99);
        v.opcode = rrs_pkg::t_opcode'(3'($urandom_range(0, 7)));
        if (sel < 25) v.opcode = rrs_pkg::OP_ADD;
        else if (sel < 33) v.opcode = rrs_pkg::OP_READ;
        if (v.opcode == rrs_pkg::OP_CLEAR && $urandom_range(0, 2) != 0)
            v.opcode = rrs_pkg::OP_ADD;
        v.entry_index = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) == 0) begin
            v.left_x = 16'($urandom);
            v.top_y = 16'($urandom);
            v.width = 15'($urandom);
            v.height = 15'($urandom);
        end else begin
            v.left_x = 16'($signed($urandom_range(0, 80)) - 40);
            v.top_y = 16'($signed($urandom_range(0, 80)) - 40);
            v.width = 15'($urandom_range(0, 40));
            v.height = 15'($urandom_range(0, 40));
        end
        return v;
    endfunction

    initial begin
        rst_n = 0;
        in_valid = 0;
        in_word = '0;
        out_ready = 0;
        calm = 0;
        n_err = 0;
        n_sent = 0;
        n_got = 0;
        idle_cyc = 0;
        rcnt = 0;
        for (int i = 0; i < NRECT; i++) rtab[i] = '{0, 0, 0, 0};
        // directed: extremes, every opcode, empty cases, overflow, bad index
        add_pending(mk_word(rrs_pkg::OP_BBOX, 0, 0, 0, 0, 0));
        add_pending(mk_word(rrs_pkg::OP_READ, 0, 0, 0, 0, 0));
        add_pending(mk_word(rrs_pkg::OP_ADD, 5, 5, 0, 10, 0));
        add_pending(mk_word(rrs_pkg::OP_CONTAIN, 5, 5, 0, 0, 0));
        add_pending(mk_word(rrs_pkg::OP_ADD, -32768, -32768, 32767, 32767, 0));
        add_pending(mk_word(rrs_pkg::OP_ADD, 32767, 32767, 32767, 32767, 0));
        add_pending(mk_word(rrs_pkg::OP_BBOX, 0, 0, 0, 0, 0));
        add_pending(mk_word(rrs_pkg::OP_READ, 0, 0, 0, 0, 1));
        add_pending(mk_word(rrs_pkg::OP_POINT, -32768, -32768, 0, 0, 0));
        add_pending(mk_word(rrs_pkg::OP_POINT, 32767, 32767, 0, 0, 0));
        add_pending(mk_word(rrs_pkg::OP_CONTAIN, -100, -100, 50, 50, 0));
        add_pending(mk_word(rrs_pkg::OP_REMOVE, -10, -10, 20, 20, 0));
        add_pending(mk_word(rrs_pkg::OP_READ, 0, 0, 0, 0, 15));
        add_pending(mk_word(rrs_pkg::OP_INTERSECT, 0, 0, 0, 0, 0));
        add_pending(mk_word(rrs_pkg::OP_ADD, 0, 0, 100, 100, 0));
        for (int i = 0; i < 4; i++)
            add_pending(mk_word(rrs_pkg::OP_REMOVE, 10 + 20 * i, 10 + 20 * i, 3, 3, 0));
        add_pending(mk_word(rrs_pkg::OP_READ, 0, 0, 0, 0, 15));
        add_pending(mk_word(rrs_pkg::OP_ADD, -50, -50, 200, 200, 0));
        add_pending(mk_word(rrs_pkg::OP_INTERSECT, 20, 20, 30, 30, 0));
        add_pending(mk_word(rrs_pkg::OP_CONTAIN, 25, 25, 10, 10, 0));
        add_pending(mk_word(rrs_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
        add_pending(mk_word(rrs_pkg::OP_ADD, 0, 0, 32767, 32767, 0));
        for (int i = 0; i < 1300; i++) add_pending(rand_word());
        repeat (4) @(posedge clk);
        rst_n <= 1;
    end

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                add_expected(region_step(in_word));
                op_seen[in_word.opcode]++;
                n_sent++;
            end
            if (!in_valid || in_ready) begin
                if (pend_words.size() > 0 && (calm || $urandom_range(0, 99) >= 20)) begin
                    in_valid <= 1;
                    in_word <= pend_words.pop_front();
                end else begin
                    in_valid <= 0;
                end
            end
            out_ready <= calm || $urandom_range(0, 99) >= 20;
            // quiet window with no idling on either side
            calm <= (n_sent > 500 && n_sent < 700);
        end
    end

    // monitor
    always @(posedge clk) begin
        rrs_pkg::t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            n_got++;
            if (exp_words.size() == 0) begin
                report_err("unexpected word", out_word, '0);
            end else begin
                want = exp_words.pop_front();
                if (out_word.status !== want.status ||
                    out_word.hit !== want.hit ||
                    out_word.entry_count !== want.entry_count ||
                    out_word.out_left_x !== want.out_left_x ||
                    out_word.out_top_y !== want.out_top_y ||
                    out_word.out_width !== want.out_width ||
                    out_word.out_height !== want.out_height)
                    report_err("field", out_word, want);
            end
        end
    end

    // watchdog and end of run
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cyc <= 0;
            else idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= WDOG) begin
                $display("watchdog: no handshake for %0d cycles", WDOG);
                $display("[FAIL] regression broken");
                $finish;
            end else if (pend_words.size() == 0 && !in_valid && exp_words.size() == 0 &&
                         idle_cyc >= 100) begin
                $display("covered %0d words: add %0d remove %0d intersect %0d point %0d",
                         n_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
                $display("contain %0d bbox %0d clear %0d read %0d, %0d results checked",
                         op_seen[4], op_seen[5], op_seen[6], op_seen[7], n_got);
                if (n_err == 0) begin
                    $display("[ OK ] regression clean");
                end else begin
                    $display("[FAIL] regression broken");
                end
                $finish;
            end
        end
    end

endmodule
